/* design/length_prefixed_ring_buffer_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed ring buffer core.
// Define ASSERT_OFF to compile the checks out.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_RING_BUFFER_CORE_MACROS_SVH
`define LENGTH_PREFIXED_RING_BUFFER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define LPRB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LPRB_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define LPRB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LPRB_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

/* design/lprb_pkg.sv */
// ----------------------------------------------------------------------------
// lprb_pkg
// Operation and status codes, field widths and the result record shared by
// the ring buffer control and the top level.
// ----------------------------------------------------------------------------
package lprb_pkg;

  localparam int LEN_W       = 12;
  localparam int SIZE_CFG_W  = 13;
  localparam int LEN_S_W     = 13;
  localparam int BYTE_W      = 8;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [1:0] {
    OP_INSERT_START = 2'd0,
    OP_INSERT_BYTE  = 2'd1,
    OP_REMOVE_START = 2'd2,
    OP_REMOVE_BYTE  = 2'd3
  } lprb_op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_OUT_OF_SEQ = 2'd3
  } lprb_status_t;

  typedef struct packed {
    lprb_status_t               status;
    logic [BYTE_W-1:0]          out_byte;
    logic                       last_byte;
    logic [LEN_W-1:0]           removed_length;
    logic signed [LEN_S_W-1:0]  insert_room;
    logic signed [LEN_S_W-1:0]  head_length;
  } lprb_result_t;

endpackage

/* design/lprb_mem.sv */
// ----------------------------------------------------------------------------
// lprb_mem
// Byte store of the ring: one write port and one read port with registered
// read data. Contents are not cleared by reset.
// ----------------------------------------------------------------------------
module lprb_mem #(
  parameter int DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [7:0]                 wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [7:0]                 rd_data
);

  logic [7:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

endmodule

/* design/lprb_ctrl.sv */
// ----------------------------------------------------------------------------
// lprb_ctrl
// Pointer and record bookkeeping of the ring. Writes headers and data into
// the byte store, reads data bytes back and reloads the head record length
// from the store whenever a freed record leaves another record behind it.
// ----------------------------------------------------------------------------
module lprb_ctrl #(
  parameter int DEPTH        = 4096,
  parameter int HEADER_BYTES = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lprb_pkg::SIZE_CFG_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lprb_pkg::lprb_op_t                  in_op,
  input  logic [lprb_pkg::LEN_W-1:0]          in_rlen,
  input  logic [lprb_pkg::BYTE_W-1:0]         in_byte,
  input  logic [lprb_pkg::LEN_W-1:0]          in_cap,
  output logic                                res_valid,
  input  logic                                res_ready,
  output lprb_pkg::lprb_result_t              res,
  output logic                                mem_wr_en,
  output logic [$clog2(DEPTH)-1:0]            mem_wr_addr,
  output logic [7:0]                          mem_wr_data,
  output logic                                mem_rd_en,
  output logic [$clog2(DEPTH)-1:0]            mem_rd_addr,
  input  logic [7:0]                          mem_rd_data
);

  import lprb_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int SW  = AW + 1;
  localparam int CW  = (SW > SIZE_CFG_W) ? SW : SIZE_CFG_W;
  localparam int XW  = CW + 1;
  localparam int HCW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int SIZE_RST = (DEPTH < 4096) ? DEPTH : 4096;

  localparam logic [CW-1:0]  DEPTH_C   = CW'(DEPTH);
  localparam logic [SW-1:0]  SIZE_INIT = SW'(SIZE_RST);
  localparam logic [SW-1:0]  HDR_S     = SW'(HEADER_BYTES);
  localparam logic [XW-1:0]  HDR_X     = XW'(HEADER_BYTES);
  localparam logic [HCW-1:0] HCNT_LAST = HCW'(HEADER_BYTES - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_HWR  = 7'b0000010,
    S_RDB  = 7'b0000100,
    S_HRD0 = 7'b0001000,
    S_HRD1 = 7'b0010000,
    S_HRD2 = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_INSERT = 3'b010,
    PH_REMOVE = 3'b100
  } phase_t;

  state_t              state;
  phase_t              phase;
  logic [SW-1:0]       size;
  logic [SW-1:0]       used;
  logic [AW-1:0]       wp;
  logic [AW-1:0]       rp;
  logic [AW-1:0]       rd_ptr;
  logic [LEN_W-1:0]    head_len;
  logic [LEN_W-1:0]    ins_rem;
  logic [LEN_W-1:0]    dlv_rem;
  logic [HCW-1:0]      hcnt;
  lprb_status_t        res_status;
  logic [7:0]          res_byte;
  logic                res_last;
  logic [LEN_W-1:0]    res_remlen;

  logic [SW-1:0]       freeb;
  logic                room_neg;
  logic [XW-1:0]       room_x;
  logic [LEN_W-1:0]    room12;
  logic                fits;
  logic [XW-1:0]       total_x;
  logic [XW-1:0]       rp_sum;
  logic [XW-1:0]       rp_free_x;
  logic [XW-1:0]       used_free_x;
  logic [XW-1:0]       ds_sum;
  logic [XW-1:0]       ds_x;
  logic [XW-1:0]       used_ins_x;
  logic [LEN_W-1:0]    dlv_first;
  logic [CW-1:0]       cfg_nz;
  logic [CW-1:0]       cfg_size;
  logic [7:0]          hdr_byte;
  logic                acc_in;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] x,
                                             input logic [SW-1:0] sz);
    logic [SW-1:0] s;
    s = {1'b0, x} + SW'(1);
    return (s == sz) ? '0 : s[AW-1:0];
  endfunction

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign acc_in    = in_valid && in_ready;

  // Space and room arithmetic on the current registers.
  always_comb begin
    freeb    = (size > used) ? (size - used) : '0;
    room_neg = (freeb < HDR_S);
    room_x   = XW'(freeb) - HDR_X;
    room12   = (room_x > XW'(4095)) ? 12'hFFF : room_x[LEN_W-1:0];
    fits     = !room_neg && (in_rlen <= room12)
               && !((HEADER_BYTES < 2) && (in_rlen > 12'd255));

    // Freeing the head record: header plus whole length, tail included.
    total_x     = HDR_X + XW'(head_len);
    rp_sum      = XW'(rp) + total_x;
    rp_free_x   = (rp_sum >= XW'(size)) ? (rp_sum - XW'(size)) : rp_sum;
    used_free_x = (XW'(used) > total_x) ? (XW'(used) - total_x) : '0;

    ds_sum = XW'(rp) + HDR_X;
    ds_x   = (ds_sum >= XW'(size)) ? (ds_sum - XW'(size)) : ds_sum;

    used_ins_x = XW'(used) + HDR_X + XW'(in_rlen);
    dlv_first  = (in_cap < head_len) ? in_cap : head_len;

    cfg_nz   = (cfg_data == '0) ? CW'(1) : CW'(cfg_data);
    cfg_size = (cfg_nz > DEPTH_C) ? DEPTH_C : cfg_nz;

    // Only the two low header bytes carry length bits.
    if (hcnt == HCW'(0)) begin
      hdr_byte = ins_rem[7:0];
    end else if ((HEADER_BYTES > 1) && (hcnt == HCW'(1))) begin
      hdr_byte = {4'b0, ins_rem[11:8]};
    end else begin
      hdr_byte = 8'd0;
    end
  end

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = wp;
    mem_wr_data = in_byte;
    mem_rd_en   = 1'b0;
    mem_rd_addr = rd_ptr;
    unique case (state)
      S_IDLE: begin
        mem_wr_en = acc_in && (in_op == OP_INSERT_BYTE) && (phase == PH_INSERT);
        mem_rd_en = acc_in && (in_op == OP_REMOVE_BYTE) && (phase == PH_REMOVE)
                    && (dlv_rem != '0);
      end
      S_HWR: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = hdr_byte;
      end
      S_HRD0: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = rp;
      end
      S_HRD1: begin
        mem_rd_en   = (HEADER_BYTES > 1);
        mem_rd_addr = ring_inc(rp, size);
      end
      S_RDB, S_HRD2, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      phase   <= PH_IDLE;
      size    <= SIZE_INIT;
      used    <= '0;
      wp      <= '0;
      rp      <= '0;
      rd_ptr  <= '0;
      ins_rem <= '0;
      dlv_rem <= '0;
      hcnt    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            // A size write empties the ring and closes any open record.
            size    <= cfg_size[SW-1:0];
            used    <= '0;
            wp      <= '0;
            rp      <= '0;
            ins_rem <= '0;
            dlv_rem <= '0;
            phase   <= PH_IDLE;
          end else if (in_valid) begin
            res_status <= ST_OK;
            res_byte   <= 8'd0;
            res_last   <= 1'b0;
            res_remlen <= '0;
            state      <= S_DONE;
            unique case (in_op)
              OP_INSERT_START: begin
                if (phase != PH_IDLE) begin
                  res_status <= ST_OUT_OF_SEQ;
                end else if (!fits) begin
                  res_status <= ST_NO_SPACE;
                end else begin
                  used    <= used_ins_x[SW-1:0];
                  ins_rem <= in_rlen;
                  if (used == '0) begin
                    head_len <= in_rlen;
                  end
                  phase <= (in_rlen != '0) ? PH_INSERT : PH_IDLE;
                  hcnt  <= '0;
                  state <= S_HWR;
                end
              end
              OP_INSERT_BYTE: begin
                if (phase != PH_INSERT) begin
                  res_status <= ST_OUT_OF_SEQ;
                end else begin
                  wp      <= ring_inc(wp, size);
                  ins_rem <= ins_rem - 12'd1;
                  if (ins_rem == 12'd1) begin
                    phase <= PH_IDLE;
                  end
                end
              end
              OP_REMOVE_START: begin
                if (phase != PH_IDLE) begin
                  res_status <= ST_OUT_OF_SEQ;
                end else if (used == '0) begin
                  res_status <= ST_EMPTY;
                end else begin
                  res_remlen <= head_len;
                  if (dlv_first == '0) begin
                    rp      <= rp_free_x[AW-1:0];
                    used    <= used_free_x[SW-1:0];
                    dlv_rem <= '0;
                    state   <= (used_free_x != '0) ? S_HRD0 : S_DONE;
                  end else begin
                    dlv_rem <= dlv_first;
                    rd_ptr  <= ds_x[AW-1:0];
                    phase   <= PH_REMOVE;
                  end
                end
              end
              OP_REMOVE_BYTE: begin
                if ((phase != PH_REMOVE) || (dlv_rem == '0)) begin
                  res_status <= ST_OUT_OF_SEQ;
                end else begin
                  rd_ptr  <= ring_inc(rd_ptr, size);
                  dlv_rem <= dlv_rem - 12'd1;
                  state   <= S_RDB;
                end
              end
            endcase
          end
        end
        S_HWR: begin
          wp   <= ring_inc(wp, size);
          hcnt <= hcnt + HCW'(1);
          if (hcnt == HCNT_LAST) begin
            state <= S_DONE;
          end
        end
        S_RDB: begin
          res_byte <= mem_rd_data;
          if (dlv_rem == '0) begin
            // Last delivered byte frees the record, cut-off tail included.
            res_last <= 1'b1;
            rp       <= rp_free_x[AW-1:0];
            used     <= used_free_x[SW-1:0];
            phase    <= PH_IDLE;
            state    <= (used_free_x != '0) ? S_HRD0 : S_DONE;
          end else begin
            state <= S_DONE;
          end
        end
        S_HRD0: begin
          state <= S_HRD1;
        end
        S_HRD1: begin
          head_len <= {4'b0, mem_rd_data};
          state    <= (HEADER_BYTES > 1) ? S_HRD2 : S_DONE;
        end
        S_HRD2: begin
          head_len[11:8] <= mem_rd_data[3:0];
          state          <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid = (state == S_DONE);

  always_comb begin
    res.status         = res_status;
    res.out_byte       = res_byte;
    res.last_byte      = res_last;
    res.removed_length = res_remlen;
    res.insert_room    = room_neg ? -13'sd1 : $signed({1'b0, room12});
    res.head_length    = (used == '0) ? -13'sd1 : $signed({1'b0, head_len});
  end

endmodule

/* design/length_prefixed_ring_buffer_core.sv */
// ----------------------------------------------------------------------------
// length_prefixed_ring_buffer_core
// A result reaches m_axis through the controller's result registers and the
// output register; remove_byte first reads the store, insert_start writes its
// HEADER_BYTES header bytes, and a freed record with another behind it reloads
// the head length through the single read port of the store. No new item is
// taken until the last result is handed on. Reset empties the ring and sets
// the size to 4096 (or DEPTH if smaller); the byte store is not cleared.
// ----------------------------------------------------------------------------
`include "length_prefixed_ring_buffer_core_macros.svh"

module length_prefixed_ring_buffer_core #(
  parameter int DEPTH        = 4096,
  parameter int HEADER_BYTES = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lprb_pkg::SIZE_CFG_W-1:0]     cfg_data,     // buffer_size
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // record_length[11:0], data_byte[19:12], read_capacity[31:20]
  input  logic [lprb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic [1:0]                          s_axis_tuser, // operation
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_byte[7:0], removed_length[19:8], insert_room[32:20],
  // head_length[45:33], zero[47:46]
  output logic [lprb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic [1:0]                          m_axis_tuser, // status
  output logic                                m_axis_tlast  // last_byte
);

  import lprb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic              res_valid;
  logic              res_ready;
  lprb_result_t      res;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [7:0]        mem_wr_data;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [7:0]        mem_rd_data;
  logic              out_valid;
  lprb_result_t      out_q;

  lprb_ctrl #(
    .DEPTH        (DEPTH),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_op       (lprb_op_t'(s_axis_tuser)),
    .in_rlen     (s_axis_tdata[11:0]),
    .in_byte     (s_axis_tdata[19:12]),
    .in_cap      (s_axis_tdata[31:20]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  lprb_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output register: a finished item waits here while the core moves on.
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last_byte;
  assign m_axis_tdata  = {2'b00, out_q.head_length, out_q.insert_room,
                          out_q.removed_length, out_q.out_byte};

  `LPRB_ASSERT_NEVER(a_cfg_item_excl, clk, rst, cfg_valid && cfg_ready && s_axis_tvalid && s_axis_tready, "config write and item accepted together")
  `LPRB_ASSERT_IMP(a_empty_head, clk, rst, out_valid && (out_q.status == ST_EMPTY), out_q.head_length == -13'sd1, "empty status with a head record")
  `LPRB_ASSERT_IMP(a_last_ok, clk, rst, out_valid && out_q.last_byte, out_q.status == ST_OK, "last byte flagged on a refused item")

endmodule
